// File: rtl/tapid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tapid_pkg: shared types and constants of the three-axis PID controller
// Fixed-point formats, pipeline depth, register indexes and the constants
// of the velocity clamp and the heading wrap.
// ----------------------------------------------------------------------------
package tapid_pkg;

	// Fixed-point formats.
	localparam int FRAC_BITS = 16;
	localparam int SUM_W     = 48;
	localparam int POS_W     = 32;
	localparam int GAIN_W    = 32;
	localparam int HDG_W     = 19;
	localparam int VEL_W     = 19;
	localparam int YAW_W     = 15;
	localparam int ERR_W     = POS_W + 1;
	localparam int DERR_W    = ERR_W + 1;
	localparam int LO_W      = SUM_W / 2;
	localparam int HI_W      = SUM_W - LO_W;
	localparam int ACC_W     = SUM_W + GAIN_W + 2;

	// Number of pipeline stages from the input to the output register.
	localparam int PIPE_DEPTH = 6;

	// Configuration port.
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic [CFG_AW-1:0] REG_GOAL_X     = 3'd0;
	localparam logic [CFG_AW-1:0] REG_GOAL_Y     = 3'd1;
	localparam logic [CFG_AW-1:0] REG_GOAL_Z     = 3'd2;
	localparam logic [CFG_AW-1:0] REG_GOAL_HDG   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_PROP_GAIN  = 3'd4;
	localparam logic [CFG_AW-1:0] REG_INTEG_GAIN = 3'd5;
	localparam logic [CFG_AW-1:0] REG_DERIV_GAIN = 3'd6;
	localparam logic [CFG_AW-1:0] REG_ARMED      = 3'd7;

	// Stream widths: payload packed from the lowest bit up, padded to bytes.
	localparam int S_DATA_RAW = 3 * POS_W + HDG_W;
	localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
	localparam int M_DATA_RAW = 3 * VEL_W + YAW_W;
	localparam int M_DATA_W   = ((M_DATA_RAW + 7) / 8) * 8;

	// Two pi, rounded to nearest from a 48-bit fraction.
	localparam longint unsigned TWO_PI_Q48  = 64'h0006_487E_D511_0B46;
	localparam longint unsigned TWO_PI_FULL =
		(TWO_PI_Q48 + (64'd1 << (47 - FRAC_BITS))) >> (48 - FRAC_BITS);
	localparam int WRAP_W = HDG_W + 2;
	localparam logic signed [WRAP_W-1:0] TWO_PI = WRAP_W'(TWO_PI_FULL);

	// Division by five: multiply by the reciprocal and shift.
	localparam int QUOT_W     = HDG_W - 2;
	localparam int DIV5_SHIFT = 18;
	localparam int DIV5_W     = 16;
	localparam logic [DIV5_W-1:0] DIV5_MUL = DIV5_W'(((1 << DIV5_SHIFT) + 4) / 5);

	// Velocity clamp at plus or minus 2.0.
	localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(2) <<< (2 * FRAC_BITS);
	localparam logic signed [VEL_W-1:0] VEL_LIM = VEL_W'(2) <<< FRAC_BITS;

	// Gains shared by the three axis lanes.
	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gains_t;

	// Pipeline control: one load strobe per stage.
	typedef struct packed {
		logic [PIPE_DEPTH-1:0] load;
	} pipe_ctl_t;

endpackage
`default_nettype wire

// File: rtl/tapid_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tapid_lane: PID core for one axis
// Error, saturating integrator, derivative and the three gain products,
// summed at full precision and clamped to plus or minus 2.0.
// ----------------------------------------------------------------------------
module tapid_lane (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire tapid_pkg::pipe_ctl_t               ctl,
	input  wire logic signed [tapid_pkg::POS_W-1:0] goal,
	input  wire logic signed [tapid_pkg::POS_W-1:0] pos,
	input  wire tapid_pkg::gains_t                  gains,
	output logic signed [tapid_pkg::VEL_W-1:0]      vel
);
	import tapid_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	logic signed [ERR_W-1:0]              e_s1;
	logic signed [ERR_W-1:0]              e_s2;
	logic signed [DERR_W-1:0]             de_s2;
	logic signed [SUM_W-1:0]              sum_s2;
	logic signed [SUM_W-1:0]              sum_q;
	logic signed [ERR_W-1:0]              prev_q;
	logic signed [SUM_W:0]                sum_ext;
	logic signed [SUM_W-1:0]              sum_next;
	logic signed [ERR_W+GAIN_W:0]         pe_s3;
	logic signed [DERR_W+GAIN_W:0]        pd_s3;
	logic signed [LO_W+GAIN_W+1:0]        ilo_s3;
	logic signed [HI_W+GAIN_W:0]          ihi_s3;
	logic signed [ACC_W-1:0]              ip_s4;
	logic signed [ACC_W-1:0]              pp_s4;
	logic signed [ACC_W-1:0]              acc_s5;
	logic signed [VEL_W-1:0]              vel_s6;

	// Stage 1: position error.
	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			e_s1 <= ERR_W'(goal) - ERR_W'(pos);
		end
	end

	// Saturating integrator update.
	always_comb begin
		sum_ext = (SUM_W+1)'(sum_q) + (SUM_W+1)'(e_s1);
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_next = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_next = sum_ext[SUM_W-1:0];
		end
	end

	// Stage 2: per-axis state and derivative.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (ctl.load[1]) begin
			sum_q  <= sum_next;
			prev_q <= e_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			e_s2   <= e_s1;
			sum_s2 <= sum_next;
			de_s2  <= DERR_W'(e_s1) - DERR_W'(prev_q);
		end
	end

	// Stage 3: gain products; the integral product is split in two halves.
	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			pe_s3  <= e_s2 * $signed({1'b0, gains.kp});
			pd_s3  <= de_s2 * $signed({1'b0, gains.kd});
			ilo_s3 <= $signed({1'b0, sum_s2[LO_W-1:0]}) * $signed({1'b0, gains.ki});
			ihi_s3 <= $signed(sum_s2[SUM_W-1:LO_W]) * $signed({1'b0, gains.ki});
		end
	end

	// Stage 4: partial sums.
	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			ip_s4 <= (ACC_W'(ihi_s3) <<< LO_W) + ACC_W'(ilo_s3);
			pp_s4 <= ACC_W'(pe_s3) + ACC_W'(pd_s3);
		end
	end

	// Stage 5: full-precision command.
	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			acc_s5 <= ip_s4 + pp_s4;
		end
	end

	// Stage 6: clamp exactly at plus or minus 2.0, otherwise round down.
	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			if (acc_s5 > ACC_LIM) begin
				vel_s6 <= VEL_LIM;
			end else if (acc_s5 < -ACC_LIM) begin
				vel_s6 <= -VEL_LIM;
			end else begin
				vel_s6 <= acc_s5[FRAC_BITS+VEL_W-1:FRAC_BITS];
			end
		end
	end

	assign vel = vel_s6;

endmodule
`default_nettype wire

// File: rtl/tapid_yaw.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tapid_yaw: yaw-rate lane
// Heading error wrapped into [0, 2 pi) and divided by twenty, aligned with
// the pipeline of the velocity lanes.
// ----------------------------------------------------------------------------
module tapid_yaw (
	input  wire logic                               clk,
	input  wire tapid_pkg::pipe_ctl_t               ctl,
	input  wire logic signed [tapid_pkg::HDG_W-1:0] goal_hdg,
	input  wire logic signed [tapid_pkg::HDG_W-1:0] hdg,
	output logic [tapid_pkg::YAW_W-1:0]             yaw_rate
);
	import tapid_pkg::*;

	logic signed [WRAP_W-1:0]       d_s1;
	logic signed [WRAP_W-1:0]       wrap;
	logic [HDG_W-1:0]               r_s2;
	logic [QUOT_W+DIV5_W-1:0]       q_s3;
	logic [YAW_W-1:0]               yaw_s4;
	logic [YAW_W-1:0]               yaw_s5;
	logic [YAW_W-1:0]               yaw_s6;

	// Stage 1: heading difference.
	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			d_s1 <= WRAP_W'(goal_hdg) - WRAP_W'(hdg);
		end
	end

	// The difference lies within two turns either way, so one of four
	// shifted copies falls into [0, 2 pi).
	always_comb begin
		if (d_s1 >= TWO_PI) begin
			wrap = d_s1 - TWO_PI;
		end else if (d_s1 >= 0) begin
			wrap = d_s1;
		end else if (d_s1 >= -TWO_PI) begin
			wrap = d_s1 + TWO_PI;
		end else begin
			wrap = d_s1 + (TWO_PI <<< 1);
		end
	end

	// Stage 2: wrapped difference.
	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			r_s2 <= wrap[HDG_W-1:0];
		end
	end

	// Stage 3: quarter of the difference times the reciprocal of five.
	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			q_s3 <= (QUOT_W+DIV5_W)'(r_s2[HDG_W-1:2]) * (QUOT_W+DIV5_W)'(DIV5_MUL);
		end
	end

	// Stages 4 to 6: quotient, delayed to meet the velocity lanes.
	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			yaw_s4 <= q_s3[DIV5_SHIFT+YAW_W-1:DIV5_SHIFT];
		end
		if (ctl.load[4]) begin
			yaw_s5 <= yaw_s4;
		end
		if (ctl.load[5]) begin
			yaw_s6 <= yaw_s5;
		end
	end

	assign yaw_rate = yaw_s6;

endmodule
`default_nettype wire

// File: rtl/three_axis_pid_with_yaw_wrap.sv
// A request passes through six register stages on its way to m_tvalid; the edge
// that accepts the request loads the first of them.
// Throughput: one request per cycle; each stage moves on as soon as the next one
// has room, so only a full pipeline with m_tready low stalls s_tready.
// While armed_q is 0, requests are accepted and dropped with no state change.
// Reset clears the configuration registers, the integrators, the previous errors and all
// valid flags; the block is ready in the first cycle after reset.
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_pid_with_yaw_wrap: three-axis PID controller with yaw wrap
// Configuration registers, pipeline control, three axis lanes and the yaw
// lane, merged into one result on the master stream.
// ----------------------------------------------------------------------------
module three_axis_pid_with_yaw_wrap (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [tapid_pkg::CFG_AW-1:0]     cfg_addr,
	input  wire logic [tapid_pkg::CFG_DW-1:0]     cfg_wdata,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// pos_x[31:0], pos_y[63:32], pos_z[95:64], heading[114:96], zero padding
	input  wire logic [tapid_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// vel_x[18:0], vel_y[37:19], vel_z[56:38], yaw_rate[71:57]
	output logic [tapid_pkg::M_DATA_W-1:0]        m_tdata
);
	import tapid_pkg::*;

	logic signed [POS_W-1:0]   goal_x_q;
	logic signed [POS_W-1:0]   goal_y_q;
	logic signed [POS_W-1:0]   goal_z_q;
	logic signed [HDG_W-1:0]   goal_hdg_q;
	gains_t                    gains_q;
	logic                      armed_q;
	logic [PIPE_DEPTH-1:0]     valid_q;
	logic [PIPE_DEPTH-1:0]     vin;
	logic [PIPE_DEPTH-1:0]     adv;
	pipe_ctl_t                 ctl;
	logic signed [VEL_W-1:0]   vel_x;
	logic signed [VEL_W-1:0]   vel_y;
	logic signed [VEL_W-1:0]   vel_z;
	logic [YAW_W-1:0]          yaw_rate;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q   <= '0;
			goal_y_q   <= '0;
			goal_z_q   <= '0;
			goal_hdg_q <= '0;
			gains_q    <= '0;
			armed_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_GOAL_X:     goal_x_q   <= cfg_wdata[POS_W-1:0];
				REG_GOAL_Y:     goal_y_q   <= cfg_wdata[POS_W-1:0];
				REG_GOAL_Z:     goal_z_q   <= cfg_wdata[POS_W-1:0];
				REG_GOAL_HDG:   goal_hdg_q <= cfg_wdata[HDG_W-1:0];
				REG_PROP_GAIN:  gains_q.kp <= cfg_wdata[GAIN_W-1:0];
				REG_INTEG_GAIN: gains_q.ki <= cfg_wdata[GAIN_W-1:0];
				REG_DERIV_GAIN: gains_q.kd <= cfg_wdata[GAIN_W-1:0];
				REG_ARMED:      armed_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Valid chain: a stage advances when it is empty or the next one advances.
	always_comb begin
		adv[PIPE_DEPTH-1] = !valid_q[PIPE_DEPTH-1] || m_tready;
		for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
		vin[0] = s_tvalid && armed_q;
		for (int k = 1; k < PIPE_DEPTH; k++) begin
			vin[k] = valid_q[k-1];
		end
		ctl.load = adv & vin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < PIPE_DEPTH; k++) begin
				if (adv[k]) begin
					valid_q[k] <= vin[k];
				end
			end
		end
	end

	assign s_tready = adv[0];
	assign m_tvalid = valid_q[PIPE_DEPTH-1];

	// Axis lanes.
	tapid_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.goal   (goal_x_q),
		.pos    (s_tdata[POS_W-1:0]),
		.gains  (gains_q),
		.vel    (vel_x)
	);

	tapid_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.goal   (goal_y_q),
		.pos    (s_tdata[2*POS_W-1:POS_W]),
		.gains  (gains_q),
		.vel    (vel_y)
	);

	tapid_lane u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.goal   (goal_z_q),
		.pos    (s_tdata[3*POS_W-1:2*POS_W]),
		.gains  (gains_q),
		.vel    (vel_z)
	);

	// Yaw lane.
	tapid_yaw u_yaw (
		.clk      (clk),
		.ctl      (ctl),
		.goal_hdg (goal_hdg_q),
		.hdg      (s_tdata[3*POS_W+HDG_W-1:3*POS_W]),
		.yaw_rate (yaw_rate)
	);

	// Merge the lane results into one result word.
	assign m_tdata = M_DATA_W'({yaw_rate, vel_z, vel_y, vel_x});

endmodule
`default_nettype wire

// File: rtl/tapid_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tapid_checker: port checks of the three-axis PID controller
// Watches the streams for ranges of the results, flow control and stalls.
// ----------------------------------------------------------------------------
module tapid_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	input  wire logic                             s_tready,
	input  wire logic                             m_tvalid,
	input  wire logic                             m_tready,
	input  wire logic [tapid_pkg::M_DATA_W-1:0]   m_tdata
);
	import tapid_pkg::*;

	logic signed [VEL_W-1:0] vx;
	logic signed [VEL_W-1:0] vy;
	logic signed [VEL_W-1:0] vz;
	logic [YAW_W-1:0]        yr;

	assign vx = m_tdata[VEL_W-1:0];
	assign vy = m_tdata[2*VEL_W-1:VEL_W];
	assign vz = m_tdata[3*VEL_W-1:2*VEL_W];
	assign yr = m_tdata[3*VEL_W+YAW_W-1:3*VEL_W];

	// Velocity commands never exceed the clamp.
	a_vel_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (vx <= VEL_LIM && vx >= -VEL_LIM && vy <= VEL_LIM &&
			vy >= -VEL_LIM && vz <= VEL_LIM && vz >= -VEL_LIM))
		else $error("velocity command beyond the clamp");

	// The yaw rate stays below a twentieth of two pi.
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (YAW_W+1)'(yr) * (YAW_W+6)'(20) < (YAW_W+6)'(TWO_PI))
		else $error("yaw rate beyond the wrapped range");

	// With no result waiting, an offered request is taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !m_tvalid |-> s_tready)
		else $error("input stalled while no result is waiting");

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind three_axis_pid_with_yaw_wrap tapid_checker u_tapid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
